>>> hdl/qva_pkg.sv
// Shared types, constants and the arctangent table for the vector angle block.
package qva_pkg;

  // Datapath widths: CORDIC x/y, angle accumulator, scaled operands
  localparam int XW    = 36;
  localparam int ZW    = 34;
  localparam int FW    = 30;
  localparam int ITERS = 30;

  localparam logic [29:0]          INV_GAIN = 30'd652032874;
  localparam logic signed [ZW-1:0] HALF_PI  = 34'sd1686629713;
  localparam logic signed [ZW-1:0] PI_30    = 34'sd3373259426;

  // One pipeline beat
  typedef struct packed {
    logic                 vld;
    logic                 spec;  // answer already fixed in z
    logic                 dneg;  // dot product negative
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [FW-1:0]        uz;
    logic [FW-1:0]        ud;
  } qva_beat_t;

  // atan(2^-i) with 30 fraction bits
  function automatic logic signed [ZW-1:0] arc_entry(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043836;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = ZW'(34'sd1 <<< (30 - i));
    endcase
    return r;
  endfunction

endpackage

>>> hdl/qva_front.sv
// Front end: products, cross/dot sums, magnitudes, normalization to 30 bits.
module qva_front #(
  parameter int CW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [CW-1:0] a_x_i,
  input  logic signed [CW-1:0] a_y_i,
  input  logic signed [CW-1:0] a_z_i,
  input  logic signed [CW-1:0] a_w_i,
  input  logic signed [CW-1:0] b_x_i,
  input  logic signed [CW-1:0] b_y_i,
  input  logic signed [CW-1:0] b_z_i,
  input  logic signed [CW-1:0] b_w_i,
  output qva_pkg::qva_beat_t beat_o
);
  import qva_pkg::*;

  localparam int EW = (CW > 31) ? 31 : CW;
  localparam int PS = CW - EW;
  localparam int SW = 2 * EW + 2;
  localparam int PW = $clog2(SW);
  localparam int MW = (SW > FW) ? SW : FW;

  logic signed [CW-1:0]   raw [8];
  logic signed [EW-1:0]   cmp [8];
  logic signed [2*EW-1:0] pm_q [4][4];
  logic                   v1_q, v2_q, v3_q, v4_q;
  logic signed [SW-1:0]   dx_q, dy_q, dz_q, dot_q;
  logic [SW-1:0]          mag_d [4];
  logic [SW-1:0]          mag_q [4];
  logic [PW-1:0]          p_d, p_q;
  logic                   dzero_q, czero_q, dneg_q;
  qva_beat_t              beat_d, beat_q;

  assign raw[0] = a_x_i;
  assign raw[1] = a_y_i;
  assign raw[2] = a_z_i;
  assign raw[3] = a_w_i;
  assign raw[4] = b_x_i;
  assign raw[5] = b_y_i;
  assign raw[6] = b_z_i;
  assign raw[7] = b_w_i;

  // Narrow over-wide components, truncating toward zero
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      logic signed [CW:0] ext;
      logic signed [CW:0] bias;
      ext  = (CW+1)'(raw[k]);
      bias = raw[k][CW-1] ? (((CW+1)'(1) <<< PS) - (CW+1)'(1)) : '0;
      cmp[k] = EW'((ext + bias) >>> PS);
    end
  end

  // Stage 1: all a_i * b_j products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        pm_q[i][j] <= cmp[i] * cmp[4+j];
      end
    end
  end

  // Stage 2: cross terms and dot product (index 0..3 = x,y,z,w)
  always_ff @(posedge clk_i) begin
    dx_q  <= SW'(pm_q[3][0]) - SW'(pm_q[0][3]) - SW'(pm_q[1][2]) + SW'(pm_q[2][1]);
    dy_q  <= SW'(pm_q[3][1]) - SW'(pm_q[1][3]) - SW'(pm_q[2][0]) + SW'(pm_q[0][2]);
    dz_q  <= SW'(pm_q[3][2]) - SW'(pm_q[2][3]) - SW'(pm_q[0][1]) + SW'(pm_q[1][0]);
    dot_q <= SW'(pm_q[0][0]) + SW'(pm_q[1][1]) + SW'(pm_q[2][2]) + SW'(pm_q[3][3]);
  end

  // Stage 3: magnitudes, special cases, top set bit
  always_comb begin
    logic [SW-1:0] all;
    mag_d[0] = dx_q[SW-1]  ? SW'(-dx_q)  : SW'(dx_q);
    mag_d[1] = dy_q[SW-1]  ? SW'(-dy_q)  : SW'(dy_q);
    mag_d[2] = dz_q[SW-1]  ? SW'(-dz_q)  : SW'(dz_q);
    mag_d[3] = dot_q[SW-1] ? SW'(-dot_q) : SW'(dot_q);
    all = mag_d[0] | mag_d[1] | mag_d[2] | mag_d[3];
    p_d = '0;
    for (int k = 0; k < SW; k++) begin
      if (all[k]) p_d = PW'(k);
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    p_q     <= p_d;
    dzero_q <= (dot_q == '0);
    czero_q <= (dx_q == '0) && (dy_q == '0) && (dz_q == '0);
    dneg_q  <= dot_q[SW-1];
  end

  // Stage 4: common shift so the top set bit lands on bit 29
  always_comb begin
    logic [FW-1:0] sc [4];
    for (int k = 0; k < 4; k++) begin
      if (int'(p_q) > FW - 1) begin
        sc[k] = FW'(MW'(mag_q[k]) >> (int'(p_q) - (FW - 1)));
      end else begin
        sc[k] = FW'(MW'(mag_q[k]) << ((FW - 1) - int'(p_q)));
      end
    end
    beat_d      = '0;
    beat_d.dneg = dneg_q;
    beat_d.x    = XW'(sc[0]);
    beat_d.y    = XW'(sc[1]);
    beat_d.uz   = sc[2];
    beat_d.ud   = sc[3];
    beat_d.spec = dzero_q | czero_q;
    if (dzero_q) begin
      beat_d.z = HALF_PI;
    end else if (czero_q && dneg_q) begin
      beat_d.z = PI_30;
    end else begin
      beat_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  // Valid bits through the four stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    beat_o     = beat_q;
    beat_o.vld = v4_q;
  end

endmodule

>>> hdl/qva_cordic_stage.sv
// One registered CORDIC vectoring iteration.
module qva_cordic_stage #(
  parameter int ITER = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qva_pkg::qva_beat_t beat_i,
  output qva_pkg::qva_beat_t beat_o
);
  import qva_pkg::*;

  qva_beat_t beat_d, beat_q;
  logic      vld_q;

  // Rotate toward the x axis; special beats pass untouched
  always_comb begin
    logic signed [XW-1:0] sx, sy;
    sx     = beat_i.x >>> ITER;
    sy     = beat_i.y >>> ITER;
    beat_d = beat_i;
    if (!beat_i.spec) begin
      if (!beat_i.y[XW-1]) begin
        beat_d.x = beat_i.x + sy;
        beat_d.y = beat_i.y - sx;
        beat_d.z = beat_i.z + arc_entry(ITER);
      end else begin
        beat_d.x = beat_i.x - sy;
        beat_d.y = beat_i.y + sx;
        beat_d.z = beat_i.z - arc_entry(ITER);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_i.vld;
    end
  end

  always_comb begin
    beat_o     = beat_q;
    beat_o.vld = vld_q;
  end

endmodule

>>> hdl/qva_gain.sv
// CORDIC gain removal and setup of the next vectoring pass.
module qva_gain #(
  parameter bit FINAL = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qva_pkg::qva_beat_t beat_i,
  output qva_pkg::qva_beat_t beat_o
);
  import qva_pkg::*;

  qva_beat_t beat_d, beat_q;
  logic      vld_q;

  always_comb begin
    logic [63:0]          prod;
    logic signed [XW-1:0] g;
    prod   = 64'(beat_i.x[33:0]) * 64'(INV_GAIN);
    g      = XW'(prod[63:30]);
    beat_d = beat_i;
    if (!beat_i.spec) begin
      if (!FINAL) begin
        // second pass: combine with |dz|
        beat_d.x = g;
        beat_d.y = XW'(beat_i.uz);
        beat_d.z = '0;
      end else if (beat_i.dneg) begin
        beat_d.x = g;
        beat_d.y = XW'(beat_i.ud);
        beat_d.z = HALF_PI;
      end else begin
        beat_d.x = XW'(beat_i.ud);
        beat_d.y = g;
        beat_d.z = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= beat_i.vld;
    end
  end

  always_comb begin
    beat_o     = beat_q;
    beat_o.vld = vld_q;
  end

endmodule

>>> hdl/quaternion_vector_angle.sv
// Angle between two 4-component vectors: top level with the CORDIC chain.
//
// Takes one vector pair per clock whenever start_i is high (busy_o stays low)
// and returns atan2(|cross|, dot) in radians, 0..pi, with ANGLE_FRACTION_BITS
// fraction bits, on angle_rad_o for one cycle marked by done_o. The pipeline is
// four front-end stages (products, sums, magnitudes, normalization),
// three 30-iteration CORDIC passes of one register stage per iteration, two
// gain multiply stages and one rounding stage. Results leave in input order
// and must be taken in the cycle that done_o is high.
module quaternion_vector_angle #(
  parameter int COMPONENT_WIDTH     = 16,
  parameter int ANGLE_FRACTION_BITS = 13
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [COMPONENT_WIDTH-1:0] a_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] a_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] b_w_i,
  output logic                             done_o,
  output logic [ANGLE_FRACTION_BITS+1:0]   angle_rad_o
);
  import qva_pkg::*;

  localparam int AW = ANGLE_FRACTION_BITS + 2;
  localparam int SH = FW - ANGLE_FRACTION_BITS;

  qva_beat_t v1 [ITERS+1];
  qva_beat_t v2 [ITERS+1];
  qva_beat_t v3 [ITERS+1];
  logic [AW-1:0] angle_d, angle_q;
  logic          done_q;

  assign busy_o = 1'b0;

  qva_front #(.CW(COMPONENT_WIDTH)) u_front (
    .clk_i, .rst_ni, .start_i,
    .a_x_i, .a_y_i, .a_z_i, .a_w_i,
    .b_x_i, .b_y_i, .b_z_i, .b_w_i,
    .beat_o(v1[0])
  );

  // Three vectoring passes with gain removal between them
  for (genvar i = 0; i < ITERS; i++) begin : g_pass1
    qva_cordic_stage #(.ITER(i)) u_st (.clk_i, .rst_ni, .beat_i(v1[i]), .beat_o(v1[i+1]));
  end

  qva_gain #(.FINAL(1'b0)) u_gain1 (.clk_i, .rst_ni, .beat_i(v1[ITERS]), .beat_o(v2[0]));

  for (genvar i = 0; i < ITERS; i++) begin : g_pass2
    qva_cordic_stage #(.ITER(i)) u_st (.clk_i, .rst_ni, .beat_i(v2[i]), .beat_o(v2[i+1]));
  end

  qva_gain #(.FINAL(1'b1)) u_gain2 (.clk_i, .rst_ni, .beat_i(v2[ITERS]), .beat_o(v3[0]));

  for (genvar i = 0; i < ITERS; i++) begin : g_pass3
    qva_cordic_stage #(.ITER(i)) u_st (.clk_i, .rst_ni, .beat_i(v3[i]), .beat_o(v3[i+1]));
  end

  // Clamp to 0..pi, round half up to the output precision
  always_comb begin
    logic signed [ZW-1:0] zc;
    logic [ZW:0]          sum;
    zc = v3[ITERS].z;
    if (zc < 0) begin
      zc = '0;
    end else if (zc > PI_30) begin
      zc = PI_30;
    end
    sum     = (ZW+1)'(unsigned'(zc)) + ((ZW+1)'(1) << (SH - 1));
    angle_d = AW'(sum >> SH);
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v3[ITERS].vld;
    end
  end

  assign done_o      = done_q;
  assign angle_rad_o = angle_q;

endmodule
